### rtl/core/ssm_pkg.sv
`timescale 1ns / 1ps

package ssm_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RES     = 32;
	localparam int CMD_DEPTH   = 2;

	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int RES_W     = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH_A = 2'd0,
		OP_PUSH_B = 2'd1,
		OP_END_A  = 2'd2,
		OP_END_B  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DATA    = 2'd0,
		ST_DROPPED = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef struct packed {
		op_t                           op;
		logic signed [DATA_WIDTH-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  merged_value;
		logic                          from_b;
		status_t                       status;
		logic                          final_res;
		logic                          last;
	} out_item_t;

	// decoded command: push or end mark, and which stream it names
	typedef struct packed {
		logic                          push;
		logic                          is_b;
		logic signed [DATA_WIDTH-1:0]  value;
	} cmd_t;

endpackage

### rtl/core/ssm_front.sv
`timescale 1ns / 1ps

module ssm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ssm_pkg::in_item_t item,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output ssm_pkg::cmd_t    cmd
);
	import ssm_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;

	assign item_ready = !valid_s1 || cmd_ready;
	assign cmd_valid  = valid_s1;
	assign cmd        = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// op decode
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cmd_s1.push  <= (item.op == OP_PUSH_A) || (item.op == OP_PUSH_B);
			cmd_s1.is_b  <= (item.op == OP_PUSH_B) || (item.op == OP_END_B);
			cmd_s1.value <= item.value;
		end
	end

endmodule

### rtl/core/ssm_cmd_fifo.sv
`timescale 1ns / 1ps

module ssm_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  ssm_pkg::cmd_t wr_cmd,
	output logic          rd_valid,
	input  logic          rd_ready,
	output ssm_pkg::cmd_t rd_cmd
);
	import ssm_pkg::*;

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 wr;
	logic                 rd;

	assign wr_ready = cnt_q != CMD_CNT_W'(CMD_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

### rtl/core/ssm_back.sv
`timescale 1ns / 1ps

module ssm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  ssm_pkg::cmd_t     cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output ssm_pkg::out_item_t res
);
	import ssm_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_MERGE
	} state_t;

	state_t                       state_q;
	logic signed [DATA_WIDTH-1:0] qa_q [QUEUE_DEPTH];
	logic signed [DATA_WIDTH-1:0] qb_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]             ca_q, cb_q;
	logic [PTR_W-1:0]             ha_q, hb_q;
	logic                         ea_q, eb_q, done_q;
	logic [RES_W-1:0]             n_q;
	logic                         out_valid_q;
	out_item_t                    out_q;

	logic signed [DATA_WIDTH-1:0] head_a, head_b;
	logic                         a_ne, b_ne, settled, take_b;
	logic [CNT_W-1:0]             ca_n, cb_n;
	logic                         settled_n, complete_n, complete_now, cap;
	logic                         slot_free, cmd_take, blocked, full;
	logic                         push_a, push_b, pop_a, pop_b;
	logic                         emit;
	out_item_t                    res_d;

	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
	                                             input logic [CNT_W-1:0] cnt);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(ptr) + (CNT_W+1)'(cnt);
		if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign head_a = qa_q[ha_q];
	assign head_b = qb_q[hb_q];
	assign a_ne   = ca_q != '0;
	assign b_ne   = cb_q != '0;

	// next choice is settled: both heads present, or one side ended and drained
	assign settled = (a_ne && b_ne) || (!a_ne && ea_q && b_ne) || (!b_ne && eb_q && a_ne);
	// ties go to b
	assign take_b  = (a_ne && b_ne) ? (head_a >= head_b) : !a_ne;

	// look one pop ahead to mark the last result of this command
	assign ca_n       = take_b ? ca_q : ca_q - 1'b1;
	assign cb_n       = take_b ? cb_q - 1'b1 : cb_q;
	assign settled_n  = ((ca_n != '0) && (cb_n != '0)) ||
	                    ((ca_n == '0) && ea_q && (cb_n != '0)) ||
	                    ((cb_n == '0) && eb_q && (ca_n != '0));
	assign complete_n   = ea_q && eb_q && (ca_n == '0) && (cb_n == '0);
	assign complete_now = ea_q && eb_q && !a_ne && !b_ne;
	assign cap          = n_q == RES_W'(MAX_RES - 1);

	assign slot_free = !out_valid_q || res_ready;
	assign cmd_ready = (state_q == S_IDLE) && slot_free;
	assign cmd_take  = cmd_valid && cmd_ready;
	assign blocked   = done_q || (cmd.is_b ? eb_q : ea_q);
	assign full      = (cmd.is_b ? cb_q : ca_q) == CNT_W'(QUEUE_DEPTH);

	assign push_a = cmd_take && cmd.push && !blocked && !full && !cmd.is_b;
	assign push_b = cmd_take && cmd.push && !blocked && !full && cmd.is_b;
	assign pop_a  = (state_q == S_MERGE) && slot_free && settled && !take_b;
	assign pop_b  = (state_q == S_MERGE) && slot_free && settled && take_b;

	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_take && cmd.push && !blocked && full) begin
					emit          = 1'b1;
					res_d.from_b  = cmd.is_b;
					res_d.status  = ST_DROPPED;
					res_d.last    = 1'b1;
				end
			end
			S_MERGE: begin
				if (slot_free && settled) begin
					emit               = 1'b1;
					res_d.merged_value = take_b ? head_b : head_a;
					res_d.from_b       = take_b;
					res_d.status       = ST_DATA;
					res_d.final_res    = complete_n;
					res_d.last         = !settled_n || cap;
				end else if (slot_free && complete_now) begin
					emit            = 1'b1;
					res_d.status    = ST_EMPTY;
					res_d.final_res = 1'b1;
					res_d.last      = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ca_q        <= '0;
			cb_q        <= '0;
			ha_q        <= '0;
			hb_q        <= '0;
			ea_q        <= 1'b0;
			eb_q        <= 1'b0;
			done_q      <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q       <= res_d;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end

			if (push_a) begin
				ca_q <= ca_q + 1'b1;
			end
			if (push_b) begin
				cb_q <= cb_q + 1'b1;
			end
			if (pop_a) begin
				ca_q <= ca_q - 1'b1;
				ha_q <= ptr_inc(ha_q);
			end
			if (pop_b) begin
				cb_q <= cb_q - 1'b1;
				hb_q <= ptr_inc(hb_q);
			end

			case (state_q)
				S_IDLE: begin
					n_q <= '0;
					if (cmd_take && !done_q) begin
						if (!cmd.push) begin
							if (cmd.is_b) begin
								eb_q <= 1'b1;
							end else begin
								ea_q <= 1'b1;
							end
							state_q <= S_MERGE;
						end else if (!blocked && !full) begin
							state_q <= S_MERGE;
						end
					end
				end
				S_MERGE: begin
					if (settled) begin
						if (slot_free) begin
							if (!settled_n || cap) begin
								done_q  <= complete_n;
								state_q <= S_IDLE;
							end else begin
								n_q <= n_q + 1'b1;
							end
						end
					end else if (complete_now) begin
						if (slot_free) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// element storage, written at the tail on an accepted push
	always_ff @(posedge clk) begin
		if (push_a) begin
			qa_q[ptr_add(ha_q, ca_q)] <= cmd.value;
		end
		if (push_b) begin
			qb_q[ptr_add(hb_q, cb_q)] <= cmd.value;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ca_q <= CNT_W'(QUEUE_DEPTH)) && (cb_q <= CNT_W'(QUEUE_DEPTH)))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_a |-> a_ne) and (pop_b |-> b_ne))
		else $error("pop from empty queue");

	a_quiet_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !emit)
		else $error("result after merge completed");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_d.last) |=> (state_q == S_IDLE))
		else $error("command still active after its last result");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_d.final_res) |-> res_d.last)
		else $error("final result not marked last");

endmodule

### rtl/core/sorted_stream_merge_core.sv
`timescale 1ns / 1ps

// Merges two ascending signed streams A and B into one ascending stream of
// results. Each transfer on the item channel pushes a value into queue A or B
// (each QUEUE_DEPTH deep) or marks the end of a stream; after it the core
// emits merged values as long as the next choice is settled, at most MAX_RES
// per item, B first on ties, and flags the last result of each item and the
// final result of the merge. An item enters a one-stage decode register, then
// a two-entry command queue, so the item side keeps taking transfers while the
// merge engine works, until that queue is full. The merge engine runs one
// command at a time. A push that is dropped on a full queue or ignored after
// its stream's end mark, and any item after completion, is handled in the
// idle state alone. Any other item takes the engine to the merge state, which
// emits results through a single head compare while the next choice is settled
// and returns to idle after the last result of the item, or when nothing is
// settled. A result register separates the engine from the result channel,
// so the engine stalls only in cycles where a result waits in that register
// and the result channel is not ready. No clearing pass follows reset.

module sorted_stream_merge_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  ssm_pkg::in_item_t  item,
	output logic               res_valid,
	input  logic               res_ready,
	output ssm_pkg::out_item_t res
);
	import ssm_pkg::*;

	// decoded command between front and command queue
	logic cmd_in_valid;
	logic cmd_in_ready;
	cmd_t cmd_in;

	// command queue to merge engine
	logic cmd_out_valid;
	logic cmd_out_ready;
	cmd_t cmd_out;

	// front: accepts item transfers and decodes the op
	ssm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (cmd_in_valid),
		.cmd_ready  (cmd_in_ready),
		.cmd        (cmd_in)
	);

	// short command queue, lets front and engine stall on their own
	ssm_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cmd_in_valid),
		.wr_ready (cmd_in_ready),
		.wr_cmd   (cmd_in),
		.rd_valid (cmd_out_valid),
		.rd_ready (cmd_out_ready),
		.rd_cmd   (cmd_out)
	);

	// back: element queues, end marks and the merge decision
	ssm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_out_valid),
		.cmd_ready (cmd_out_ready),
		.cmd       (cmd_out),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
